[rtl/core/ipf_pkg.sv]
package ipf_pkg;

  localparam int ENTRIES    = 16;
  localparam int MAX_CHARS  = 16;
  localparam int DEPTH      = ENTRIES * MAX_CHARS;

  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ENT_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int LEN_W      = $clog2(MAX_CHARS + 1);
  localparam int LVL_W      = $clog2(MAX_CHARS);

  localparam int CHAR_W     = 8;
  localparam int CMD_W      = 2;
  localparam int FIELD_W    = 4;
  localparam int EIU_W      = 5;
  localparam int OUT_MASK_W = 16;
  localparam int OUT_LEN_W  = 5;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 2;

  localparam int REG_EIU    = 0;
  localparam logic [EIU_W-1:0] EIU_RESET = EIU_W'(16);

  localparam logic [CHAR_W-1:0] CH_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_D_0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_D_9  = 8'h39;

  typedef logic [ENTRIES-1:0] mask_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_BACK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_ctl_t;

  typedef struct packed {
    logic              clr;
    logic              en;
    logic [ENT_W-1:0]  idx;
    logic              prev_bit;
    logic [CHAR_W-1:0] key;
  } cmp_ctl_t;

  function automatic logic is_alnum(logic [CHAR_W-1:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           ((c >= CH_D_0)  && (c <= CH_D_9));
  endfunction

  function automatic mask_t all_mask(logic [EIU_W-1:0] n);
    mask_t m;
    for (int i = 0; i < ENTRIES; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

  function automatic logic [OUT_MASK_W-1:0] out_mask(mask_t m);
    logic [OUT_MASK_W+ENTRIES-1:0] w;
    w = {{OUT_MASK_W{1'b0}}, m};
    return w[OUT_MASK_W-1:0];
  endfunction

  function automatic logic [OUT_LEN_W-1:0] out_len(logic [LEN_W-1:0] l);
    logic [OUT_LEN_W+LEN_W-1:0] w;
    w = {{OUT_LEN_W{1'b0}}, l};
    return w[OUT_LEN_W-1:0];
  endfunction

endpackage

[rtl/core/ipf_ram.sv]
module ipf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ipf_cmp.sv]
module ipf_cmp import ipf_pkg::*; (
  input  logic              clk,
  input  cmp_ctl_t          ctl,
  input  logic [CHAR_W-1:0] rd_char,
  input  logic              rd_valid,
  output mask_t             acc
);

  logic hit;

  // unloaded positions read back with rd_valid low and never match the key
  assign hit = ctl.prev_bit && rd_valid && (rd_char == ctl.key);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.en) begin
      acc[ctl.idx] <= hit;
    end
  end

endmodule

[rtl/core/ipf_ctrl.sv]
module ipf_ctrl import ipf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [CMD_W-1:0]      command,
  input  logic [FIELD_W-1:0]    entry_number,
  input  logic [FIELD_W-1:0]    char_position,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [EIU_W-1:0]      entries_in_use,
  input  mask_t                 acc,
  output logic                  busy,
  output ram_ctl_t              ram_ctl,
  output cmp_ctl_t              cmp_ctl,
  output logic                  done,
  output logic [OUT_MASK_W-1:0] match_mask,
  output logic [OUT_LEN_W-1:0]  prefix_length,
  output logic                  key_ignored
);

  state_t             state;
  state_t             state_next;
  cmd_t               cmd_in;
  cmd_t               cmd_q;
  logic [CHAR_W-1:0]  key_q;
  logic [FIELD_W-1:0] ent_q;
  logic [FIELD_W-1:0] pos_q;
  logic               rej;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_next;
  logic [LEN_W-1:0]   len_dec;
  logic [LEN_W-1:0]   len_next_dec;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_dec;
  logic [ADDR_W-1:0]  scan_addr;
  mask_t              stack [MAX_CHARS];
  mask_t              prev_mask;
  mask_t              res_mask;
  logic               accept;
  logic               key_ok;
  logic               load_ok;
  logic               push;

  assign cmd_in       = cmd_t'(command);
  assign accept       = start && (state == ST_IDLE);
  assign key_ok       = is_alnum(char_code) && (int'(len) < MAX_CHARS);
  assign load_ok      = (int'(ent_q) < ENTRIES) && (int'(pos_q) < MAX_CHARS);
  assign push         = (cmd_q == CMD_KEY) && !rej;
  assign len_dec      = len - LEN_W'(1);
  assign len_next_dec = len_next - LEN_W'(1);
  assign cnt_dec      = cnt - CNT_W'(1);
  assign prev_mask    = (len == '0) ? all_mask(entries_in_use) : stack[len_dec[LVL_W-1:0]];

  always_comb begin
    len_next = len;
    case (cmd_q)
      CMD_KEY: begin
        if (!rej) len_next = len + LEN_W'(1);
      end
      CMD_BACK: begin
        if (len != '0) len_next = len_dec;
      end
      CMD_CLEAR: begin
        len_next = '0;
      end
      default: begin
        len_next = len;
      end
    endcase
  end

  always_comb begin
    if (push) begin
      res_mask = acc;
    end else if (len_next == '0) begin
      res_mask = all_mask(entries_in_use);
    end else begin
      res_mask = stack[len_next_dec[LVL_W-1:0]];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ((cmd_in == CMD_KEY) && key_ok) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (int'(cnt) == ENTRIES) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy             = (state != ST_IDLE);
    ram_ctl          = '0;
    cmp_ctl.clr      = accept;
    cmp_ctl.en       = 1'b0;
    cmp_ctl.idx      = cnt_dec[ENT_W-1:0];
    cmp_ctl.prev_bit = prev_mask[cnt_dec[ENT_W-1:0]];
    cmp_ctl.key      = key_q;
    case (state)
      ST_SCAN: begin
        if (int'(cnt) < ENTRIES) ram_ctl.raddr = scan_addr;
        cmp_ctl.en = (cnt != '0);
      end
      ST_FINISH: begin
        ram_ctl.we    = (cmd_q == CMD_LOAD) && load_ok;
        ram_ctl.waddr = ADDR_W'(int'(ent_q) * MAX_CHARS + int'(pos_q));
        ram_ctl.wdata = key_q;
      end
      default: begin
        ram_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      len   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FINISH);
      if (state == ST_FINISH) len <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= cmd_in;
      key_q     <= char_code;
      ent_q     <= entry_number;
      pos_q     <= char_position;
      rej       <= (cmd_in == CMD_KEY) && !key_ok;
      cnt       <= '0;
      scan_addr <= ADDR_W'(len);
    end else if (state == ST_SCAN) begin
      cnt       <= cnt + CNT_W'(1);
      scan_addr <= scan_addr + ADDR_W'(MAX_CHARS);
    end
    if (state == ST_FINISH) begin
      if (push) stack[len[LVL_W-1:0]] <= acc;
      match_mask    <= out_mask(res_mask);
      prefix_length <= out_len(len_next);
      key_ignored   <= rej;
    end
  end

endmodule

[rtl/core/incremental_prefix_filter.sv]
// Channel   Handshake               Payload
// config    psel/penable/pwrite     paddr, pwdata, prdata (entries_in_use)
// command   start, busy             command, entry_number, char_position, char_code
// result    done (one-cycle strobe) match_mask, prefix_length, key_ignored
//
// A typed key that is accepted stays busy through the scan, which reads one
// entry's character a cycle from the single read port of the string RAM and runs
// it through one comparator. Every other command skips the scan.
// done rises in the cycle after busy falls; a new command may start in that cycle.
// Reset clears the prefix length, the character valid bits and sets
// entries_in_use to 16; no clearing pass. The receiver cannot stall results.
module incremental_prefix_filter import ipf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      command,
  input  logic [FIELD_W-1:0]    entry_number,
  input  logic [FIELD_W-1:0]    char_position,
  input  logic [CHAR_W-1:0]     char_code,
  output logic                  done,
  output logic [OUT_MASK_W-1:0] match_mask,
  output logic [OUT_LEN_W-1:0]  prefix_length,
  output logic                  key_ignored
);

  logic [EIU_W-1:0]  entries_in_use;
  logic              reg_sel;
  ram_ctl_t          ram_ctl;
  cmp_ctl_t          cmp_ctl;
  mask_t             acc;
  logic [CHAR_W-1:0] rd_char;
  logic              rd_valid;
  logic [DEPTH-1:0]  loaded;

  assign pready  = 1'b1;
  assign reg_sel = (int'(paddr >> 2) == REG_EIU);
  assign prdata  = reg_sel ? {{(APB_DW-EIU_W){1'b0}}, entries_in_use} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= EIU_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      entries_in_use <= pwdata[EIU_W-1:0];
    end
  end

  // mark loaded positions; unloaded ones read back with rd_valid low
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (ram_ctl.we) begin
      loaded[ram_ctl.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= loaded[ram_ctl.raddr];
  end

  ipf_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wdata),
    .raddr (ram_ctl.raddr),
    .rdata (rd_char)
  );

  ipf_cmp u_cmp (
    .clk      (clk),
    .ctl      (cmp_ctl),
    .rd_char  (rd_char),
    .rd_valid (rd_valid),
    .acc      (acc)
  );

  ipf_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .command        (command),
    .entry_number   (entry_number),
    .char_position  (char_position),
    .char_code      (char_code),
    .entries_in_use (entries_in_use),
    .acc            (acc),
    .busy           (busy),
    .ram_ctl        (ram_ctl),
    .cmp_ctl        (cmp_ctl),
    .done           (done),
    .match_mask     (match_mask),
    .prefix_length  (prefix_length),
    .key_ignored    (key_ignored)
  );

endmodule

[rtl/core/ipf_checker.sv]
module ipf_checker import ipf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [CMD_W-1:0]      command,
  input logic                  done,
  input logic [OUT_LEN_W-1:0]  prefix_length
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted without going busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result strobe outside the cycle after busy falls");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == CMD_CLEAR)) |=> ##1 (done && (prefix_length == '0)))
    else $error("clear did not return an empty prefix");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(prefix_length) <= MAX_CHARS))
    else $error("prefix length beyond maximum");

endmodule

bind incremental_prefix_filter ipf_checker u_ipf_checker (.*);

[verif/tb_top.sv]
module tb_top;
  import ipf_pkg::*;

  localparam int LIMIT = 400000;
  localparam int HOLD = ENTRIES + 4;
  localparam int PAD_W = APB_DW - EIU_W;
  localparam logic [APB_AW-1:0] EIU_ADDR = APB_AW'(4 * REG_EIU);

  typedef struct packed {
    logic [OUT_MASK_W-1:0] mask;
    logic [OUT_LEN_W-1:0]  len;
    logic                  ign;
  } outcome_t;

  class prefix_tracker;
    logic [CHAR_W-1:0] char_store [ENTRIES][MAX_CHARS];
    mask_t             level_masks [MAX_CHARS];
    int                cur_len;
    logic [EIU_W-1:0]  in_use;
    outcome_t          pending_q [$];
    int                errors;

    function new();
      foreach (char_store[e, p]) char_store[e][p] = '0;
      foreach (level_masks[l]) level_masks[l] = '0;
      cur_len = 0;
      in_use = EIU_RESET;
      errors = 0;
    endfunction

    static function bit letter_or_digit(logic [CHAR_W-1:0] c);
      return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
             (c >= CH_D_0 && c <= CH_D_9);
    endfunction

    function mask_t base_mask();
      mask_t m;
      int n;
      n = int'(in_use);
      if (n > ENTRIES) n = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) m[i] = (i < n);
      return m;
    endfunction

    function mask_t head_mask();
      if (cur_len == 0) return base_mask();
      return level_masks[cur_len-1];
    endfunction

    function void write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      if (addr == EIU_ADDR) in_use = data[EIU_W-1:0];
    endfunction

    function void note_command(cmd_t cmd, logic [FIELD_W-1:0] ent,
                               logic [FIELD_W-1:0] pos, logic [CHAR_W-1:0] code);
      outcome_t o;
      mask_t    prev;
      mask_t    nxt;
      logic     ign;
      ign = 1'b0;
      case (cmd)
        CMD_LOAD: begin
          if (int'(ent) < ENTRIES && int'(pos) < MAX_CHARS) char_store[ent][pos] = code;
        end
        CMD_KEY: begin
          if (!letter_or_digit(code) || cur_len >= MAX_CHARS) begin
            ign = 1'b1;
          end else begin
            prev = head_mask();
            nxt = '0;
            for (int i = 0; i < ENTRIES; i++) begin
              if (prev[i] && char_store[i][cur_len] == code) nxt[i] = 1'b1;
            end
            level_masks[cur_len] = nxt;
            cur_len++;
          end
        end
        CMD_BACK: begin
          if (cur_len > 0) cur_len--;
        end
        default: begin
          cur_len = 0;
        end
      endcase
      o.mask = OUT_MASK_W'(head_mask());
      o.len = OUT_LEN_W'(cur_len);
      o.ign = ign;
      pending_q.insert(pending_q.size(), o);
    endfunction

    function void check_result(logic [OUT_MASK_W-1:0] mask, logic [OUT_LEN_W-1:0] len,
                               logic ign);
      outcome_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual mask %h len %0d ignored %b",
                 $time, mask, len, ign);
        return;
      end
      e = pending_q.pop_front();
      if (mask !== e.mask) begin
        errors++;
        $display("%0t: match_mask expected %h actual %h", $time, e.mask, mask);
      end
      if (len !== e.len) begin
        errors++;
        $display("%0t: prefix_length expected %0d actual %0d", $time, e.len, len);
      end
      if (ign !== e.ign) begin
        errors++;
        $display("%0t: key_ignored expected %b actual %b", $time, e.ign, ign);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      command;
  logic [FIELD_W-1:0]    entry_number;
  logic [FIELD_W-1:0]    char_position;
  logic [CHAR_W-1:0]     char_code;
  logic                  done;
  logic [OUT_MASK_W-1:0] match_mask;
  logic [OUT_LEN_W-1:0]  prefix_length;
  logic                  key_ignored;

  prefix_tracker sb;
  int            cycles;
  int            sent_items;
  bit            gap_free;

  incremental_prefix_filter i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .entry_number  (entry_number),
    .char_position (char_position),
    .char_code     (char_code),
    .done          (done),
    .match_mask    (match_mask),
    .prefix_length (prefix_length),
    .key_ignored   (key_ignored)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pwrite && pready) sb.write_reg(paddr, pwdata);
      if (start && !busy) sb.note_command(cmd_t'(command), entry_number, char_position,
                                          char_code);
      if (done) sb.check_result(match_mask, prefix_length, key_ignored);
    end
  end

  function automatic logic [CHAR_W-1:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return CH_LO_A + CHAR_W'(r);
    if (r < 52) return CH_UP_A + CHAR_W'(r - 26);
    return CH_D_0 + CHAR_W'(r - 52);
  endfunction

  function automatic logic [CHAR_W-1:0] load_char();
    logic [CHAR_W-1:0] pool [8];
    pool = '{CH_LO_A, CH_LO_A + 8'd1, CH_LO_A + 8'd2, CH_LO_Z, CH_UP_A, CH_UP_Z,
             CH_D_0, CH_D_9};
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 7)];
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // favour the next character of an entry still in the running
  function automatic logic [CHAR_W-1:0] guided_key();
    int                r;
    int                e;
    mask_t             m;
    logic [CHAR_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 75 && sb.cur_len < MAX_CHARS) begin
      m = sb.head_mask();
      e = $urandom_range(0, ENTRIES - 1);
      for (int k = 0; k < ENTRIES; k++) begin
        if (m[(e + k) % ENTRIES]) begin
          e = (e + k) % ENTRIES;
          break;
        end
      end
      c = sb.char_store[e][sb.cur_len];
      if (prefix_tracker::letter_or_digit(c)) return c;
    end
    if (r < 90) return rand_alnum();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic pause();
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (gap_free || r < 55) g = 0;
    else if (r < 90) g = $urandom_range(1, 3);
    else g = $urandom_range(8, 40);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send(input cmd_t cmd, input logic [FIELD_W-1:0] ent,
                      input logic [FIELD_W-1:0] pos, input logic [CHAR_W-1:0] code);
    start <= 1'b1;
    command <= cmd;
    entry_number <= ent;
    char_position <= pos;
    char_code <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent_items++;
    pause();
  endtask

  task automatic send_op(input cmd_t cmd, input logic [CHAR_W-1:0] code);
    send(cmd, FIELD_W'($urandom_range(0, 15)), FIELD_W'($urandom_range(0, 15)), code);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (HOLD) @(negedge clk);
  endtask

  task automatic apb_write(input logic [EIU_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= EIU_ADDR;
    pwdata <= {PAD_W'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic fill_table();
    int len;
    for (int e = 0; e < ENTRIES; e++) begin
      len = ($urandom_range(0, 4) == 0) ? MAX_CHARS : $urandom_range(1, 6);
      for (int p = 0; p < len; p++) send(CMD_LOAD, FIELD_W'(e), FIELD_W'(p), load_char());
    end
  endtask

  task automatic run_phase(input int quota);
    int goal;
    int kind;
    int len;
    int back_pct;
    goal = sent_items + quota;
    gap_free = ($urandom_range(0, 3) == 0);
    while (sent_items < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        if ($urandom_range(0, 3) != 0) send_op(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_CHARS, MAX_CHARS + 3)
                                          : $urandom_range(1, 6);
        back_pct = (len >= MAX_CHARS) ? 2 : 12;
        repeat (len) begin
          if ($urandom_range(0, 99) < back_pct) send_op(CMD_BACK, CHAR_W'($urandom));
          else send_op(CMD_KEY, guided_key());
        end
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 6)) begin
          send(CMD_LOAD, FIELD_W'($urandom_range(0, 15)),
               FIELD_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                    : $urandom_range(0, 15)),
               load_char());
        end
      end else if (kind < 97) begin
        send(cmd_t'($urandom_range(0, 3)), FIELD_W'($urandom_range(0, 15)),
             FIELD_W'($urandom_range(0, 15)), CHAR_W'($urandom_range(0, 255)));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    int settings [7];
    sb = new();
    cycles = 0;
    sent_items = 0;
    gap_free = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    command = CMD_LOAD;
    entry_number = '0;
    char_position = '0;
    char_code = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(CMD_LOAD, 4'd0, 4'd0, CH_LO_A);
    send(CMD_LOAD, 4'd0, 4'd1, CH_LO_Z);
    send(CMD_LOAD, 4'd15, 4'd15, 8'hFF);
    send(CMD_LOAD, 4'd15, 4'd0, CH_UP_Z);
    send(CMD_LOAD, 4'd1, 4'd0, CH_UP_A);
    send(CMD_LOAD, 4'd2, 4'd0, CH_D_0);
    send(CMD_LOAD, 4'd3, 4'd0, CH_D_9);
    send_op(CMD_KEY, CH_LO_A);
    send_op(CMD_KEY, CH_LO_Z);
    send_op(CMD_BACK, 8'h00);
    send_op(CMD_BACK, 8'hFF);
    send_op(CMD_BACK, CH_LO_A);
    send_op(CMD_KEY, 8'h00);
    send_op(CMD_KEY, CH_D_0 - 8'd1);
    send_op(CMD_KEY, CH_D_9 + 8'd1);
    send_op(CMD_KEY, CH_UP_Z + 8'd1);
    send_op(CMD_KEY, CH_LO_A - 8'd1);
    send_op(CMD_KEY, CH_LO_Z + 8'd1);
    send_op(CMD_KEY, 8'hFF);
    send_op(CMD_KEY, CH_UP_A);
    send_op(CMD_CLEAR, 8'h00);
    send_op(CMD_KEY, CH_D_0);
    send_op(CMD_KEY, CH_D_9);
    send_op(CMD_CLEAR, 8'hFF);
    send_op(CMD_KEY, CH_UP_Z);

    settings = '{16, 1, 31, 0, 17, 0, 16};
    settings[5] = $urandom_range(2, 15);
    for (int p = 0; p < 7; p++) begin
      drain();
      apb_write(EIU_W'(settings[p]));
      if (p == 0) fill_table();
      run_phase(60);
    end
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/ipf_pkg.sv
rtl/core/ipf_ram.sv
rtl/core/ipf_cmp.sv
rtl/core/ipf_ctrl.sv
rtl/core/incremental_prefix_filter.sv
rtl/core/ipf_checker.sv
verif/tb_top.sv
